[hdl/dcsa_pkg.sv]
// ----------------------------------------------------------------------------
// dcsa_pkg: shared definitions for the dual channel signed averager
// Word codes, field widths and the command and status groups that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package dcsa_pkg;

	localparam int SAMPLE_BITS_DEF = 10;
	localparam int COUNT_BITS_DEF  = 15;

	localparam int MODE_W = 2;
	localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_AVG    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	localparam int AVG_W     = 11;
	localparam int AVG_LIMIT = 1023;

	typedef struct packed {
		logic sample_en;
		logic clear_en;
		logic div_start;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

endpackage

[hdl/dcsa_if.sv]
// ----------------------------------------------------------------------------
// dcsa_if: stream channels of the dual channel signed averager
// dcsa_in_if carries input words, dcsa_out_if carries average words.
// ----------------------------------------------------------------------------
interface dcsa_in_if #(
	parameter int SAMPLE_BITS = dcsa_pkg::SAMPLE_BITS_DEF
);
	logic                            valid;
	logic                            ready;
	logic [dcsa_pkg::MODE_W-1:0]     mode;
	logic [SAMPLE_BITS-1:0]          sample_value;
	logic                            dir_left;
	logic                            dir_right;

	modport source (output valid, mode, sample_value, dir_left, dir_right, input ready);
	modport sink   (input valid, mode, sample_value, dir_left, dir_right, output ready);
endinterface

interface dcsa_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [dcsa_pkg::AVG_W-1:0] avg_left;
	logic signed [dcsa_pkg::AVG_W-1:0] avg_right;
	logic                             left_empty;
	logic                             right_empty;
	logic                             overflowed;

	modport source (output valid, avg_left, avg_right, left_empty, right_empty, overflowed,
		input ready);
	modport sink   (input valid, avg_left, avg_right, left_empty, right_empty, overflowed,
		output ready);
endinterface

[hdl/dual_channel_signed_average.sv]
// ----------------------------------------------------------------------------
// dual_channel_signed_average: accumulate-and-dump averager for two channels
// Sums signed motor-speed samples per channel and reports truncated averages,
// saturated to +/-1023.
// Usage: words arrive on the samples channel. A sample word (mode 0) is added
// to the selected channel's sum, or subtracted when that channel's direction
// bit is set, and the channel toggles; the first sample after reset goes to
// the right channel. A clear word (mode 2) zeroes sums, counts and the
// overflow flag. Mode 3 words are taken and ignored. Sample and clear words
// finish in the cycle they are accepted, so while no division runs one word
// per cycle is taken. An average word (mode 1) snapshots both sums and
// counts, clears them and starts a restoring divider that produces one
// quotient bit per cycle in both lanes at once. It needs SAMPLE_BITS +
// COUNT_BITS steps (25 by default); the result word is then loaded and shown
// on the averages channel; the samples channel is held off until then. Empty
// channels report 0 with their empty flag set; counts that saturate drop
// samples and raise the overflow flag. If the receiver stalls, the result
// waits in the output register and sample words are still taken; a second
// average word waits at the end of its division until the register is
// free. Reset returns to idle with zero sums and the right channel selected.
// ----------------------------------------------------------------------------
module dual_channel_signed_average #(
	parameter int SAMPLE_BITS = dcsa_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = dcsa_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dcsa_in_if.sink     samples,
	dcsa_out_if.source  averages
);
	import dcsa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The controller decides what each word does; the datapath only follows.
	dcsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_mode   (samples.mode),
		.in_ready  (samples.ready),
		.out_valid (averages.valid),
		.out_ready (averages.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dcsa_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample_value (samples.sample_value),
		.dir_left     (samples.dir_left),
		.dir_right    (samples.dir_right),
		.avg_left     (averages.avg_left),
		.avg_right    (averages.avg_right),
		.left_empty   (averages.left_empty),
		.right_empty  (averages.right_empty),
		.overflowed   (averages.overflowed)
	);

	// An accepted average word must hold off the input while the divider runs.
	a_avg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready && samples.mode == MODE_AVG) |=> !samples.ready)
		else $error("input taken during division");

	// The result register is only loaded once all quotient bits are in.
	a_load_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.div_done)
		else $error("result loaded before division finished");

	// The divider never steps past its last bit.
	a_no_extra_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !sts.div_done)
		else $error("divider stepped after completion");

	// A load makes the result visible in the next cycle.
	a_load_shows_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> averages.valid)
		else $error("loaded result not presented");

endmodule

[hdl/dcsa_ctrl.sv]
// ----------------------------------------------------------------------------
// dcsa_ctrl: controller of the dual channel signed averager
// Decodes input words, sequences the divider and owns the output valid flag.
// ----------------------------------------------------------------------------
module dcsa_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [dcsa_pkg::MODE_W-1:0] in_mode,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  dcsa_pkg::sts_t              sts,
	output dcsa_pkg::cmd_t              cmd
);
	import dcsa_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_mode)
						MODE_SAMPLE: cmd.sample_en = 1'b1;
						MODE_AVG: begin
							cmd.div_start = 1'b1;
							state_d       = ST_DIV;
						end
						MODE_CLEAR:  cmd.clear_en = 1'b1;
						default:     ;
					endcase
				end
			end
			ST_DIV: begin
				if (!sts.div_done) begin
					cmd.div_step = 1'b1;
				end else if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/dcsa_datapath.sv]
// ----------------------------------------------------------------------------
// dcsa_datapath: accumulators, two-lane serial divider and result register
// Lane 0 is the right channel and lane 1 the left channel.
// ----------------------------------------------------------------------------
module dcsa_datapath #(
	parameter int SAMPLE_BITS = dcsa_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = dcsa_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dcsa_pkg::cmd_t                    cmd,
	output dcsa_pkg::sts_t                    sts,
	input  logic [SAMPLE_BITS-1:0]            sample_value,
	input  logic                              dir_left,
	input  logic                              dir_right,
	output logic signed [dcsa_pkg::AVG_W-1:0] avg_left,
	output logic signed [dcsa_pkg::AVG_W-1:0] avg_right,
	output logic                              left_empty,
	output logic                              right_empty,
	output logic                              overflowed
);
	import dcsa_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + COUNT_BITS + 1;
	localparam int MAG_W = SUM_W - 1;
	localparam int STEPS = MAG_W;
	localparam int STEP_W = $clog2(STEPS + 1);

	logic signed [SUM_W-1:0] sum_q   [2];
	logic [COUNT_BITS-1:0]   count_q [2];
	logic                    chan_q;
	logic                    drop_q;

	logic [COUNT_BITS-1:0]   rem_q   [2];
	logic [MAG_W-1:0]        quo_q   [2];
	logic [COUNT_BITS-1:0]   den_q   [2];
	logic [1:0]              neg_q;
	logic [1:0]              empty_q;
	logic                    drop_cap_q;
	logic [STEP_W-1:0]       step_q;

	logic signed [AVG_W-1:0] avg_q   [2];
	logic [1:0]              empty_out_q;
	logic                    over_q;

	logic signed [SUM_W-1:0] sample_ext;
	logic                    dir_sel;

	assign sample_ext   = $signed({{(SUM_W-SAMPLE_BITS){1'b0}}, sample_value});
	assign dir_sel      = chan_q ? dir_left : dir_right;
	assign sts.div_done = (step_q == STEP_W'(STEPS));

	// Accumulators and channel selection.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q     <= 1'b0;
			drop_q     <= 1'b0;
			sum_q[0]   <= '0;
			sum_q[1]   <= '0;
			count_q[0] <= '0;
			count_q[1] <= '0;
		end else if (cmd.clear_en || cmd.div_start) begin
			drop_q     <= 1'b0;
			sum_q[0]   <= '0;
			sum_q[1]   <= '0;
			count_q[0] <= '0;
			count_q[1] <= '0;
		end else if (cmd.sample_en) begin
			chan_q <= ~chan_q;
			if (count_q[chan_q] == '1) begin
				drop_q <= 1'b1;
			end else begin
				sum_q[chan_q]   <= dir_sel ? sum_q[chan_q] - sample_ext
				                           : sum_q[chan_q] + sample_ext;
				count_q[chan_q] <= count_q[chan_q] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.div_start) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			drop_cap_q <= drop_q;
		end
	end

	// Restoring divider, one quotient bit per lane per cycle.
	for (genvar i = 0; i < 2; i++) begin : g_lane
		logic [COUNT_BITS:0] shifted;
		logic [COUNT_BITS:0] trial;
		logic [AVG_W-1:0]    sat;

		assign shifted = {rem_q[i], quo_q[i][MAG_W-1]};
		assign trial   = shifted - {1'b0, den_q[i]};
		assign sat     = (quo_q[i] > MAG_W'(AVG_LIMIT)) ? AVG_W'(AVG_LIMIT)
		                                                : quo_q[i][AVG_W-1:0];

		always_ff @(posedge clk) begin
			if (cmd.div_start) begin
				quo_q[i]   <= sum_q[i][SUM_W-1] ? MAG_W'(-sum_q[i]) : MAG_W'(sum_q[i]);
				rem_q[i]   <= '0;
				den_q[i]   <= count_q[i];
				neg_q[i]   <= sum_q[i][SUM_W-1];
				empty_q[i] <= (count_q[i] == '0);
			end else if (cmd.div_step) begin
				if (!trial[COUNT_BITS]) begin
					rem_q[i] <= trial[COUNT_BITS-1:0];
					quo_q[i] <= {quo_q[i][MAG_W-2:0], 1'b1};
				end else begin
					rem_q[i] <= shifted[COUNT_BITS-1:0];
					quo_q[i] <= {quo_q[i][MAG_W-2:0], 1'b0};
				end
			end
			if (cmd.out_load) begin
				if (empty_q[i]) begin
					avg_q[i] <= '0;
				end else begin
					avg_q[i] <= neg_q[i] ? -$signed(sat) : $signed(sat);
				end
				empty_out_q[i] <= empty_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			over_q <= drop_cap_q;
		end
	end

	assign avg_right   = avg_q[0];
	assign avg_left    = avg_q[1];
	assign right_empty = empty_out_q[0];
	assign left_empty  = empty_out_q[1];
	assign overflowed  = over_q;

endmodule
